>>> hdl/rhca_pkg.sv
// ----------------------------------------------------------------------------
// RGB/HLS color adjust package
// Payload structs, register indexes and constants shared by the adjust unit.
// ----------------------------------------------------------------------------
package rhca_pkg;

   // Input pixel, one transfer on the request channel
   typedef struct packed {
      logic [7:0] red_in;
      logic [7:0] green_in;
      logic [7:0] blue_in;
      logic [7:0] alpha_in;
   } pixel_in_type;

   // Adjusted pixel, one transfer on the response channel
   typedef struct packed {
      logic [7:0] red_out;
      logic [7:0] green_out;
      logic [7:0] blue_out;
      logic [7:0] alpha_out;
   } pixel_out_type;

   localparam int FACTOR_W = 19;

   // Adjust control handed to each component adjuster
   typedef struct packed {
      logic                       mode;
      logic signed [FACTOR_W-1:0] factor;
   } adj_ctl_type;

   // Register indexes
   localparam logic [1:0] CSR_ADJUST_MODE  = 2'd0;
   localparam logic [1:0] CSR_HUE_FACTOR   = 2'd1;
   localparam logic [1:0] CSR_LIGHT_FACTOR = 2'd2;
   localparam logic [1:0] CSR_SAT_FACTOR   = 2'd3;

   // Adjust modes
   localparam logic MODE_RATE = 1'b0;
   localparam logic MODE_MULT = 1'b1;

   // Factor scale: 1.0 in factor units
   localparam int FACTOR_SHIFT = 16;
   localparam int FACTOR_HALF_M1 = 32767;
   localparam logic signed [FACTOR_W:0] FACTOR_ONE = 20'sd65536;

   // Pixel range constants
   localparam int PIX_MAX     = 255;
   localparam int PIX_SUM_MAX = 510;

   // Hue sextants
   localparam logic [2:0] SEXT_RED_YELLOW    = 3'd0;
   localparam logic [2:0] SEXT_YELLOW_GREEN  = 3'd1;
   localparam logic [2:0] SEXT_GREEN_CYAN    = 3'd2;
   localparam logic [2:0] SEXT_CYAN_BLUE     = 3'd3;
   localparam logic [2:0] SEXT_BLUE_MAGENTA  = 3'd4;
   localparam logic [2:0] SEXT_MAGENTA_RED   = 3'd5;

endpackage

>>> hdl/rhca_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// One quotient bit per stage; QW stages, new operands every enabled cycle.
// ----------------------------------------------------------------------------
module rhca_div #(
   parameter int NW = 28,
   parameter int DW = 12,
   parameter int QW = 17
) (
   input  logic          clock,
   input  logic          en,
   input  logic [NW-1:0] num_in,
   input  logic [DW-1:0] den_in,
   output logic [QW-1:0] quo_out
);

   logic [DW-1:0] rem_ff [QW];
   logic [QW-1:0] low_ff [QW];
   logic [QW-1:0] quo_ff [QW];
   logic [DW-1:0] den_ff [QW];

   genvar i;
   generate
      for (i = 0; i < QW; i++) begin : g_stage
         logic [DW-1:0] rem_prev;
         logic [QW-1:0] low_prev;
         logic [QW-1:0] quo_prev;
         logic [DW-1:0] den_prev;
         logic [DW:0]   trial;
         logic          ge;
         logic [DW-1:0] rem_in;

         // select stage operands
         if (i == 0) begin : g_first
            assign rem_prev = DW'(num_in >> QW);
            assign low_prev = num_in[QW-1:0];
            assign quo_prev = '0;
            assign den_prev = den_in;
         end else begin : g_next
            assign rem_prev = rem_ff[i-1];
            assign low_prev = low_ff[i-1];
            assign quo_prev = quo_ff[i-1];
            assign den_prev = den_ff[i-1];
         end

         // shift in one numerator bit, subtract if it fits
         always_comb begin
            trial  = {rem_prev, low_prev[QW-1]};
            ge     = trial >= {1'b0, den_prev};
            rem_in = ge ? DW'(trial - {1'b0, den_prev}) : DW'(trial);
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[i] <= rem_in;
               low_ff[i] <= low_prev << 1;
               quo_ff[i] <= {quo_prev[QW-2:0], ge};
               den_ff[i] <= den_prev;
            end
         end
      end
   endgenerate

   assign quo_out = quo_ff[QW-1];

endmodule

>>> hdl/rhca_adjust.sv
// ----------------------------------------------------------------------------
// Component adjuster
// Rate or multiply adjust of one HLS component, three register stages.
// ----------------------------------------------------------------------------
module rhca_adjust
   import rhca_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic               clock,
   input  logic               en,
   input  logic [FRAC_BITS:0] comp_in,
   input  adj_ctl_type        ctl_in,
   output logic [FRAC_BITS:0] comp_out
);

   localparam int CW = FRAC_BITS + 1;
   localparam int MW = FACTOR_W - 1;
   localparam int PW = CW + MW;
   localparam logic [CW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

   logic [CW-1:0] a_in, base_in, a_ff, base_ff, base2_ff, comp_ff, comp_in_r;
   logic [MW-1:0] m_in, m_ff;
   logic [PW-1:0] prod_ff;
   logic signed [FACTOR_W:0] m_full;
   logic [PW:0]   rsum;
   logic [CW+2:0] sc;
   logic [CW+3:0] res;

   // pick operand, multiplier and base for the mode
   always_comb begin
      if (ctl_in.mode == MODE_MULT) begin
         a_in    = comp_in;
         m_full  = (FACTOR_W+1)'(ctl_in.factor);
         base_in = '0;
      end else if (!ctl_in.factor[FACTOR_W-1]) begin
         a_in    = ONE - comp_in;
         m_full  = (FACTOR_W+1)'(ctl_in.factor);
         base_in = comp_in;
      end else begin
         a_in    = comp_in;
         m_full  = FACTOR_ONE + (FACTOR_W+1)'(ctl_in.factor);
         base_in = '0;
      end
      // a non-positive multiplier scales to zero
      m_in = (m_full <= 0) ? '0 : m_full[MW-1:0];
   end

   // round the scaled value, add base and clamp
   always_comb begin
      rsum      = (PW+1)'(prod_ff) + (PW+1)'(FACTOR_HALF_M1);
      sc        = rsum[PW:FACTOR_SHIFT];
      res       = (CW+4)'(base2_ff) + (CW+4)'(sc);
      comp_in_r = (res > (CW+4)'(ONE)) ? ONE : res[CW-1:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_ff     <= a_in;
         m_ff     <= m_in;
         base_ff  <= base_in;
         prod_ff  <= PW'(a_ff) * PW'(m_ff);
         base2_ff <= base_ff;
         comp_ff  <= comp_in_r;
      end
   end

   assign comp_out = comp_ff;

endmodule

>>> hdl/rhca_byte.sv
// ----------------------------------------------------------------------------
// Channel back conversion
// Builds one 8-bit channel from cmin, cadd and the sextant value.
// ----------------------------------------------------------------------------
module rhca_byte
   import rhca_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                 clock,
   input  logic                 en,
   input  logic [FRAC_BITS+1:0] cmin_in,
   input  logic [FRAC_BITS+1:0] cadd_in,
   input  logic [FRAC_BITS:0]   x_in,
   output logic [7:0]           byte_out
);

   localparam int CW = FRAC_BITS + 1;
   localparam int PW = 2 * CW + 1;
   localparam int VW = 2 * FRAC_BITS + 4;
   localparam int WW = VW + 8;
   localparam int TW = WW + 1;

   logic [PW-1:0] p_ff;
   logic [CW:0]   cmin_ff;
   logic [VW-1:0] v_ff;
   logic [WW-1:0] w_ff;
   logic [TW-1:0] t;
   logic [TW-2*FRAC_BITS-1:0] hi;
   logic [7:0]    byte_in, byte_ff;

   // round to nearest with halves down, then saturate
   always_comb begin
      t       = TW'(w_ff) + (TW'(1) << (2 * FRAC_BITS - 1)) - TW'(1);
      hi      = t[TW-1:2*FRAC_BITS];
      byte_in = (hi > (TW-2*FRAC_BITS)'(PIX_MAX)) ? 8'(PIX_MAX) : hi[7:0];
   end

   always_ff @(posedge clock) begin
      if (en) begin
         p_ff    <= PW'(x_in) * PW'(cadd_in);
         cmin_ff <= cmin_in;
         v_ff    <= (VW'(cmin_ff) << FRAC_BITS) + VW'(p_ff);
         w_ff    <= (WW'(v_ff) << 8) - WW'(v_ff);
         byte_ff <= byte_in;
      end
   end

   assign byte_out = byte_ff;

endmodule

>>> hdl/rgb_hls_color_adjust_unit.sv
// ----------------------------------------------------------------------------
// RGB/HLS color adjust unit
// Converts RGBA pixels to HLS, adjusts each component, converts back.
// ----------------------------------------------------------------------------
//   channel   ports               payload          handshake
//   request   req_valid/ready     pixel_in_type    valid/ready
//   response  rsp_valid/ready     pixel_out_type   valid/ready
//   config    csr_wr_en/index     csr_wr_data      write strobe
//
// One pixel per cycle while the response is not stalled; FRAC_BITS + 13
// register stages. The depth is set by the front stages, the divider chain
// (one quotient bit per stage), adjust and back conversion.
// Reset clears the valid bits and the adjust registers to zero.
// A stalled response holds the whole pipeline; nothing is dropped.
module rgb_hls_color_adjust_unit
   import rhca_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pixel_in_type        req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pixel_out_type       rsp_data,
   input  logic                csr_wr_en,
   input  logic [1:0]          csr_index,
   input  logic [FACTOR_W-1:0] csr_wr_data
);

   localparam int FB  = FRAC_BITS;
   localparam int CW  = FB + 1;
   localparam int QW  = FB + 1;
   localparam int NW  = FB + 12;
   localparam int DW  = 12;
   localparam int LAT = QW + 12;
   localparam logic [CW-1:0] ONE = {1'b1, {FB{1'b0}}};

   // lightness split: 2^(FB-1) = 255 * L_COEF + L_REM
   localparam int L_COEF      = (1 << (FB - 1)) / PIX_MAX;
   localparam int L_REM       = (1 << (FB - 1)) % PIX_MAX;
   localparam int L_BIAS      = PIX_MAX / 2;
   localparam int RECIP_SHIFT = 25;
   localparam int RECIP_255   = 131587;
   localparam int LRW         = 17;
   localparam int LPW         = 35;

   // configuration registers
   logic                       mode_ff;
   logic signed [FACTOR_W-1:0] hue_f_ff, light_f_ff, sat_f_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RATE;
         hue_f_ff   <= '0;
         light_f_ff <= '0;
         sat_f_ff   <= '0;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_ADJUST_MODE:  mode_ff    <= csr_wr_data[0];
            CSR_HUE_FACTOR:   hue_f_ff   <= csr_wr_data;
            CSR_LIGHT_FACTOR: light_f_ff <= csr_wr_data;
            CSR_SAT_FACTOR:   sat_f_ff   <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // pipeline advance and valid/alpha tracking
   logic       en;
   logic       valid_sr [LAT];
   logic [7:0] alpha_sr [LAT];

   assign en        = !valid_sr[LAT-1] || rsp_ready;
   assign req_ready = en;
   assign rsp_valid = valid_sr[LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < LAT; j++) valid_sr[j] <= 1'b0;
      end else if (en) begin
         valid_sr[0] <= req_valid;
         for (int j = 1; j < LAT; j++) valid_sr[j] <= valid_sr[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         alpha_sr[0] <= req_data.alpha_in;
         for (int j = 1; j < LAT; j++) alpha_sr[j] <= alpha_sr[j-1];
      end
   end

   // stage 0: capture pixel
   logic [7:0] r_ff, g_ff, b_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         r_ff <= req_data.red_in;
         g_ff <= req_data.green_in;
         b_ff <= req_data.blue_in;
      end
   end

   // stage 1: max, min, sextant and hue offset
   logic [7:0]  mx, mn, d_in, n;
   logic [2:0]  k;
   logic [10:0] kdn_in, kdn_ff;
   logic [7:0]  d_ff;
   logic [8:0]  sum_in, sum_ff;
   logic        gray_ff;

   always_comb begin
      mx = r_ff;
      mn = r_ff;
      if (g_ff > mx) mx = g_ff;
      if (b_ff > mx) mx = b_ff;
      if (g_ff < mn) mn = g_ff;
      if (b_ff < mn) mn = b_ff;
      d_in   = mx - mn;
      sum_in = 9'(mx) + 9'(mn);
      if (r_ff == mx) begin
         if (g_ff >= b_ff) begin
            k = SEXT_RED_YELLOW;   n = g_ff - b_ff;
         end else begin
            k = SEXT_MAGENTA_RED;  n = r_ff - b_ff;
         end
      end else if (g_ff == mx) begin
         if (b_ff >= r_ff) begin
            k = SEXT_GREEN_CYAN;   n = b_ff - r_ff;
         end else begin
            k = SEXT_YELLOW_GREEN; n = g_ff - r_ff;
         end
      end else begin
         if (r_ff >= g_ff) begin
            k = SEXT_BLUE_MAGENTA; n = r_ff - g_ff;
         end else begin
            k = SEXT_CYAN_BLUE;    n = b_ff - g_ff;
         end
      end
      kdn_in = 11'(k) * 11'(d_in) + 11'(n);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         kdn_ff  <= kdn_in;
         d_ff    <= d_in;
         sum_ff  <= sum_in;
         gray_ff <= (d_in == '0);
      end
   end

   // stage 2: divider operands, rounding folded into the numerator;
   // lightness splits into a whole part and a small remainder over 255
   logic [8:0]     s_den;
   logic [NW-1:0]  h_num_in, s_num_in;
   logic [DW-1:0]  h_den_in, s_den_in;
   logic [NW-1:0]  h_num_ff, s_num_ff;
   logic [DW-1:0]  h_den_ff, s_den_ff;
   logic [LRW-1:0] l_rem_in, l_rem_ff;
   logic [CW-1:0]  l_base_in, l_base_ff;
   logic           gray2_ff;

   always_comb begin
      s_den     = (sum_ff < 9'(PIX_MAX)) ? sum_ff : 9'(PIX_SUM_MAX) - sum_ff;
      h_num_in  = (NW'(kdn_ff) << (FB + 1)) + (NW'(d_ff) << 2) + (NW'(d_ff) << 1)
                  - NW'(1);
      h_den_in  = (DW'(d_ff) << 3) + (DW'(d_ff) << 2);
      s_num_in  = (NW'(d_ff) << (FB + 1)) + NW'(s_den) - NW'(1);
      s_den_in  = DW'(s_den) << 1;
      l_rem_in  = LRW'(sum_ff) * LRW'(L_REM) + LRW'(L_BIAS);
      l_base_in = CW'(sum_ff) * CW'(L_COEF);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         h_num_ff  <= h_num_in;
         h_den_ff  <= h_den_in;
         s_num_ff  <= s_num_in;
         s_den_ff  <= s_den_in;
         l_rem_ff  <= l_rem_in;
         l_base_ff <= l_base_in;
         gray2_ff  <= gray_ff;
      end
   end

   // divider stages; gray flag and lightness travel alongside
   logic [QW-1:0]  h_quo, s_quo;
   logic           gray_sr [QW];
   logic [CW-1:0]  l_sr [QW];
   logic [LPW-1:0] l_prod;
   logic [CW-1:0]  l_in;

   rhca_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_hue (
      .clock(clock), .en(en), .num_in(h_num_ff), .den_in(h_den_ff), .quo_out(h_quo)
   );
   rhca_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_sat (
      .clock(clock), .en(en), .num_in(s_num_ff), .den_in(s_den_ff), .quo_out(s_quo)
   );

   // divide the lightness remainder by 255 with a reciprocal multiply
   always_comb begin
      l_prod = LPW'(l_rem_ff) * LPW'(RECIP_255);
      l_in   = l_base_ff + CW'(l_prod[LPW-1:RECIP_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         gray_sr[0] <= gray2_ff;
         l_sr[0]    <= l_in;
         for (int j = 1; j < QW; j++) begin
            gray_sr[j] <= gray_sr[j-1];
            l_sr[j]    <= l_sr[j-1];
         end
      end
   end

   // adjust stages; gray pixels have zero hue and saturation
   logic [CW-1:0] h_c, s_c, h_adj, l_adj, s_adj;
   adj_ctl_type   hue_ctl, light_ctl, sat_ctl;

   assign h_c       = gray_sr[QW-1] ? '0 : h_quo;
   assign s_c       = gray_sr[QW-1] ? '0 : s_quo;
   assign hue_ctl   = '{mode: mode_ff, factor: hue_f_ff};
   assign light_ctl = '{mode: mode_ff, factor: light_f_ff};
   assign sat_ctl   = '{mode: mode_ff, factor: sat_f_ff};

   rhca_adjust #(.FRAC_BITS(FB)) u_adj_hue (
      .clock(clock), .en(en), .comp_in(h_c), .ctl_in(hue_ctl), .comp_out(h_adj)
   );
   rhca_adjust #(.FRAC_BITS(FB)) u_adj_light (
      .clock(clock), .en(en), .comp_in(l_sr[QW-1]), .ctl_in(light_ctl), .comp_out(l_adj)
   );
   rhca_adjust #(.FRAC_BITS(FB)) u_adj_sat (
      .clock(clock), .en(en), .comp_in(s_c), .ctl_in(sat_ctl), .comp_out(s_adj)
   );

   // back stage 1: wrap hue, form s*l and 6h
   logic [FB-1:0]   h_wrap;
   logic [2*CW-1:0] sl_prod_ff;
   logic [FB+2:0]   h6_ff;
   logic [CW-1:0]   l1_ff, s1_ff;

   assign h_wrap = (h_adj >= ONE) ? '0 : h_adj[FB-1:0];

   always_ff @(posedge clock) begin
      if (en) begin
         sl_prod_ff <= (2*CW)'(s_adj) * (2*CW)'(l_adj);
         h6_ff      <= ((FB+3)'(h_wrap) << 2) + ((FB+3)'(h_wrap) << 1);
         l1_ff      <= l_adj;
         s1_ff      <= s_adj;
      end
   end

   // back stage 2: cmin, cadd and sextant values
   logic [2*CW:0] sl_round;
   logic [CW:0]   sl, lx, sx, cmin_in, cadd_in, cmin_ff, cadd_ff;
   logic [2:0]    hk;
   logic [CW-1:0] ha, xr_in, xg_in, xb_in, xr_ff, xg_ff, xb_ff;

   always_comb begin
      sl_round = (2*CW+1)'(sl_prod_ff) + (2*CW+1)'((ONE >> 1) - 1'b1);
      sl       = (CW+1)'(sl_round >> FB);
      lx       = (CW+1)'(l1_ff);
      sx       = (CW+1)'(s1_ff);
      if (l1_ff >= (ONE >> 1)) begin
         cmin_in = (lx + sl >= sx) ? lx + sl - sx : '0;
         cadd_in = (sx >= sl) ? (sx - sl) << 1 : '0;
      end else begin
         cmin_in = (lx >= sl) ? lx - sl : '0;
         cadd_in = sl << 1;
      end
      hk = h6_ff[FB+2:FB];
      ha = {1'b0, h6_ff[FB-1:0]};
      case (hk)
         SEXT_YELLOW_GREEN: begin
            xr_in = ONE - ha; xg_in = ONE;      xb_in = '0;
         end
         SEXT_GREEN_CYAN: begin
            xr_in = '0;       xg_in = ONE;      xb_in = ha;
         end
         SEXT_CYAN_BLUE: begin
            xr_in = '0;       xg_in = ONE - ha; xb_in = ONE;
         end
         SEXT_BLUE_MAGENTA: begin
            xr_in = ha;       xg_in = '0;       xb_in = ONE;
         end
         SEXT_MAGENTA_RED: begin
            xr_in = ONE;      xg_in = '0;       xb_in = ONE - ha;
         end
         default: begin
            xr_in = ONE;      xg_in = ha;       xb_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (en) begin
         cmin_ff <= cmin_in;
         cadd_ff <= cadd_in;
         xr_ff   <= xr_in;
         xg_ff   <= xg_in;
         xb_ff   <= xb_in;
      end
   end

   // channel builders; their last register is the output register
   logic [7:0] red_q, green_q, blue_q;

   rhca_byte #(.FRAC_BITS(FB)) u_byte_red (
      .clock(clock), .en(en), .cmin_in(cmin_ff), .cadd_in(cadd_ff), .x_in(xr_ff),
      .byte_out(red_q)
   );
   rhca_byte #(.FRAC_BITS(FB)) u_byte_green (
      .clock(clock), .en(en), .cmin_in(cmin_ff), .cadd_in(cadd_ff), .x_in(xg_ff),
      .byte_out(green_q)
   );
   rhca_byte #(.FRAC_BITS(FB)) u_byte_blue (
      .clock(clock), .en(en), .cmin_in(cmin_ff), .cadd_in(cadd_ff), .x_in(xb_ff),
      .byte_out(blue_q)
   );

   assign rsp_data = '{red_out: red_q, green_out: green_q, blue_out: blue_q,
                       alpha_out: alpha_sr[LAT-1]};

endmodule
